@@ hw/rtl/bchd_pkg.sv @@
// bchd_pkg: shared types and constants for the button click and hold detector
// holds the interval register set, event codes and register indexes
// no dependencies
package bchd_pkg;

    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned CLICKS_W   = 8;
    localparam int unsigned CFG_IDX_W  = 4;

    typedef logic [INTERVAL_W-1:0] t_ticks;
    typedef logic [CLICKS_W-1:0]   t_clicks;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;

    // interval registers, all counted in ticks
    typedef struct packed {
        t_ticks silence;
        t_ticks hold;
        t_ticks reset;
        t_ticks press_wait;
    } t_cfg;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_HOLD   = 2'd1,
        EV_CLICKS = 2'd2
    } t_event;

    // register indexes on the configuration port
    localparam t_cfg_idx REG_SILENCE    = t_cfg_idx'(0);
    localparam t_cfg_idx REG_HOLD       = t_cfg_idx'(1);
    localparam t_cfg_idx REG_RESET      = t_cfg_idx'(2);
    localparam t_cfg_idx REG_PRESS_WAIT = t_cfg_idx'(3);

    // reset values of the interval registers
    localparam t_ticks RST_SILENCE    = t_ticks'(50);
    localparam t_ticks RST_HOLD       = t_ticks'(500);
    localparam t_ticks RST_RESET      = t_ticks'(1000);
    localparam t_ticks RST_PRESS_WAIT = t_ticks'(300);

    localparam t_ticks  TICKS_MAX  = '1;
    localparam t_clicks CLICKS_MAX = '1;

endpackage

@@ hw/rtl/bchd_core.sv @@
// bchd_core: per-tick state of the detector and the single-pass step logic
// edge timer, click counter and hold flag, result computed for the current item
// depends on bchd_pkg
module bchd_core
    import bchd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_step,
    input  logic    i_level,
    output t_event  o_kind,
    output t_clicks o_total
);

    logic    r_prev_level;
    t_ticks  r_ticks;
    t_clicks r_pending;
    logic    r_holding;

    logic    n_prev_level;
    t_ticks  n_ticks;
    t_clicks n_pending;
    logic    n_holding;
    logic    edge_seen;
    t_ticks  gap;

    always_comb begin
        n_holding = r_holding;
        n_pending = r_pending;
        o_kind    = EV_NONE;
        o_total   = '0;

        // saturating advance, then restart on an edge
        gap       = (r_ticks != TICKS_MAX) ? r_ticks + t_ticks'(1) : r_ticks;
        edge_seen = (i_level != r_prev_level);
        n_ticks   = edge_seen ? '0 : gap;

        if (edge_seen && gap >= i_cfg.silence) begin
            if (i_level) begin
                if (gap > i_cfg.reset) begin
                    n_pending = '0;
                end
            end else if (n_holding) begin
                n_holding = 1'b0;
                n_pending = '0;
            end else if (n_pending != CLICKS_MAX) begin
                n_pending = n_pending + t_clicks'(1);
            end
        end
        n_prev_level = i_level;

        // polling
        if (!n_holding && i_level && n_ticks >= i_cfg.hold) begin
            n_holding = 1'b1;
            if (n_pending != CLICKS_MAX) begin
                n_pending = n_pending + t_clicks'(1);
            end
        end else if (n_pending != '0 && !n_holding && n_ticks >= i_cfg.reset) begin
            n_pending = '0;
        end else if (n_holding && !i_level) begin
            n_holding = 1'b0;
            n_pending = '0;
        end

        if (n_holding) begin
            o_kind  = EV_HOLD;
            o_total = n_pending;
        end else if (n_pending != '0 && n_ticks > i_cfg.press_wait) begin
            o_kind    = EV_CLICKS;
            o_total   = n_pending;
            n_pending = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
            r_ticks      <= '0;
            r_pending    <= '0;
            r_holding    <= 1'b0;
        end else if (i_step) begin
            r_prev_level <= n_prev_level;
            r_ticks      <= n_ticks;
            r_pending    <= n_pending;
            r_holding    <= n_holding;
        end
    end

    // a hold only lives while the button reads pressed
    a_hold_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_holding |-> r_prev_level)
        else $error("hold flag set with button released");

    // an accepted level change restarts the edge timer
    a_edge_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_level != r_prev_level) |=> (r_ticks == '0))
        else $error("edge timer not restarted on edge");

    // a reported click sequence leaves no pending count behind
    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_kind == EV_CLICKS) |=> (r_pending == '0))
        else $error("pending clicks survived a report");

    // no event carries no count
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_kind == EV_NONE) |-> (o_total == '0))
        else $error("count reported without an event");

endmodule

@@ hw/rtl/button_click_hold_detector.sv @@
// button_click_hold_detector: top level with configuration registers and result register
// instantiates bchd_core
// depends on bchd_pkg
//
// Each input item is one millisecond tick carrying the sampled button level, and every
// item gives exactly one result item: event_kind 0 (nothing), 1 (hold active, reported
// on every tick of the hold) or 2 (click sequence finished), with click_total the count
// of clicks including the hold press. The block takes one item per clock cycle while
// o_in_ready is high: the whole step is a single pass of compare and counter logic from
// the state registers to the result register, loaded as the item is accepted. The result
// register is refilled in the same cycle it is drained, so o_in_ready only drops
// while a result waits and i_out_ready is low. Four 16-bit interval registers (silence,
// hold, reset, press wait; indexes 0 to 3) are written through the configuration port,
// which is always ready; writes to other indexes are ignored. Write them only while the
// block is idle. Reset is synchronous and active low and restores the default intervals.
module button_click_hold_detector
    import bchd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_button_level,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_event_kind,
    output logic [CLICKS_W-1:0]   o_click_total,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [INTERVAL_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_event  r_event;
    t_clicks r_total;

    logic    in_accept;
    t_event  step_kind;
    t_clicks step_total;

    // the result register can take a new item whenever it is empty or being drained
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // interval registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.silence    <= RST_SILENCE;
            r_cfg.hold       <= RST_HOLD;
            r_cfg.reset      <= RST_RESET;
            r_cfg.press_wait <= RST_PRESS_WAIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SILENCE:    r_cfg.silence    <= i_cfg_data;
                REG_HOLD:       r_cfg.hold       <= i_cfg_data;
                REG_RESET:      r_cfg.reset      <= i_cfg_data;
                REG_PRESS_WAIT: r_cfg.press_wait <= i_cfg_data;
                default: ;      // unknown index, write dropped
            endcase
        end
    end

    // edge timer, click counter and hold logic
    bchd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (in_accept),
        .i_level (i_button_level),
        .o_kind  (step_kind),
        .o_total (step_total)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_event <= step_kind;
            r_total <= step_total;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_event;
    assign o_click_total = r_total;

endmodule
